// File: design/ntc_thermistor_beta_temperature_defines.svh
// Assertion macros shared by the checker of the thermistor temperature block.
// Depends on nothing; the using scope must provide clk and rst.
`ifndef NTC_THERMISTOR_BETA_TEMPERATURE_DEFINES_SVH
`define NTC_THERMISTOR_BETA_TEMPERATURE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define NTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ntc_pkg.sv
// Types and constants of the NTC thermistor temperature block.
// Depends on nothing; used by the top level and its checker.
package ntc_pkg;

  // Configuration port
  localparam int CFG_DW = 24;
  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_ADC_FULL_SCALE,
    REG_ADC_REF_MV,
    REG_DIV_SUPPLY_MV,
    REG_DIV_OHMS,
    REG_NTC_NOMINAL_OHMS,
    REG_REF_TEMP_CK,
    REG_BETA_K,
    REG_ABS_ZERO_CK
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_ADC_FULL_SCALE   = 16'd1023;
  localparam logic [15:0] RST_ADC_REF_MV       = 16'd5000;
  localparam logic [15:0] RST_DIV_SUPPLY_MV    = 16'd5000;
  localparam logic [23:0] RST_DIV_OHMS         = 24'd100000;
  localparam logic [23:0] RST_NTC_NOMINAL_OHMS = 24'd100000;
  localparam logic [15:0] RST_REF_TEMP_CK      = 16'd29815;
  localparam logic [15:0] RST_BETA_K           = 16'd3950;
  localparam logic [15:0] RST_ABS_ZERO_CK      = 16'd27315;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO,
    ST_SUPPLY,
    ST_SAT
  } status_t;

  // ln(2) in Q30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

  // Divider geometry: 17 quotient bits cover every unsaturated result
  localparam int DIV_QW = 17;
  localparam int DIV_RW = 61;
  localparam int DIV_DW = 44;

  typedef struct packed {
    logic    special;
    status_t code;
  } tag_t;

  // Leading-one search, coarse (byte) step
  typedef struct packed {
    logic [2:0]  hb;
    logic [63:0] v;
  } norm_t;

  // Leading-one search, fine step: exponent and fraction below the one
  typedef struct packed {
    logic [5:0]  e;
    logic [31:0] frac;
  } fine_t;

  // Table read for one log2
  typedef struct packed {
    logic [5:0]  e;
    logic [24:0] t0;
    logic [24:0] t1;
    logic [15:0] w;
  } tab_rd_t;

  // One restoring-division step
  typedef struct packed {
    tag_t              tag;
    logic              ovf;
    logic              dneg;
    logic [DIV_RW-1:0] r;
    logic [DIV_DW-1:0] d;
    logic [DIV_QW-1:0] q;
  } div_t;

endpackage

// File: design/ntc_ifs.sv
// Channel interfaces of the NTC thermistor temperature block.
// Depends on nothing; the payload follows the sample and result fields.
interface ntc_sample_if #(parameter int ADC_BITS = 10) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, adc_sample, input ready);
  modport sink   (input valid, adc_sample, output ready);
endinterface

interface ntc_result_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi_celsius;
  logic [1:0]         status;

  modport source (output valid, temp_centi_celsius, status, input ready);
  modport sink   (input valid, temp_centi_celsius, status, output ready);
endinterface

// File: design/ntc_thermistor_beta_temperature.sv
// NTC thermistor temperature by the Beta equation, fully pipelined.
// Depends on ntc_pkg and the channel interfaces in ntc_ifs.sv.
//
// Usage:
//   sample: one raw converter code of the thermistor divider per transaction
//     (valid/ready; accepted when both are high).
//   result: temperature in 0.01 C and a status code per transaction
//     (0 ok, 1 zero sample, 2 voltage at or above supply, 3 saturated).
//   cfg_*:  write port for the eight calibration registers; write only while
//     no transaction is in flight.
// Throughput: one sample per cycle while result.ready is high or a stage is empty.
// Pipeline: 11 arithmetic stages (products, log2 search, table and
//   interpolation, Beta denominator), a 17-stage restoring divider that
//   retires one quotient bit per stage, and the output register.
// Reset: clears all stage valid bits and loads the register defaults.
// Stall: each stage holds while its successor is full and stalled; empty
//   stages keep filling, so a waiting result does not block new samples
//   until the pipeline is full. Nothing is dropped or repeated.
module ntc_thermistor_beta_temperature
  import ntc_pkg::*;
#(
  parameter int ADC_BITS        = 10,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  ntc_sample_if.sink        sample,
  ntc_result_if.source      result,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int NS   = 29;
  localparam int DIV0 = 10;
  localparam int DQ   = DIV_QW;
  localparam int TW   = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int SW   = 32 + TW;

  // log2(1 + i/depth) in Q24, built at elaboration by repeated squaring
  typedef logic [24:0] log_tab_t [0:LOG_TABLE_DEPTH];

  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] x;
    logic [24:0] y;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
      y = '0;
      if (x >= (64'd1 << 31)) begin
        t[i] = 25'd1 << 24;
      end else begin
        for (int k = 0; k < 24; k++) begin
          x = (x * x) >> 30;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            y[23 - k] = 1'b1;
          end
        end
        t[i] = y;
      end
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  // Coarse leading-one: highest nonzero byte, shifted to the top
  function automatic norm_t norm_coarse(input logic [63:0] x);
    norm_t c;
    c.hb = '0;
    for (int b = 0; b < 8; b++) begin
      if (x[8*b +: 8] != 8'd0) c.hb = 3'(b);
    end
    c.v = x << {~c.hb, 3'b000};
    return c;
  endfunction

  // Fine leading-one within the top byte, then take the fraction bits
  function automatic fine_t norm_fine(input norm_t c);
    fine_t       f;
    logic [2:0]  lb;
    logic [63:0] n;
    lb = '0;
    for (int b = 0; b < 8; b++) begin
      if (c.v[56 + b]) lb = 3'(b);
    end
    n = c.v << ~lb;
    f.e = {c.hb, lb};
    f.frac = n[62:31];
    return f;
  endfunction

  // Table index and interpolation weight from the fraction
  function automatic tab_rd_t tab_lookup(input fine_t f);
    tab_rd_t        r;
    logic [SW-1:0]  sc;
    logic [TW-1:0]  idx;
    sc = SW'(f.frac) * SW'(LOG_TABLE_DEPTH);
    idx = sc[SW-1:32];
    r.e = f.e;
    r.t0 = LOG_TAB[idx];
    r.t1 = LOG_TAB[TW'(idx + 1'b1)];
    r.w = sc[31:16];
    return r;
  endfunction

  // Linear interpolation, result = e.frac in Q24
  function automatic logic [30:0] tab_interp(input tab_rd_t r);
    logic [24:0] diff;
    logic [40:0] prod;
    logic [24:0] fr;
    diff = r.t1 - r.t0;
    prod = 41'(diff) * 41'(r.w);
    fr = r.t0 + prod[40:16];
    return {1'b0, r.e, 24'd0} + 31'(fr);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) return TEMP_MAX;
    if (v < -19'sd32768) return TEMP_MIN;
    return v[15:0];
  endfunction

  // Configuration registers
  logic [15:0] adc_full_scale;
  logic [15:0] adc_ref_millivolt;
  logic [15:0] divider_supply_millivolt;
  logic [23:0] divider_ohms;
  logic [23:0] ntc_nominal_ohms;
  logic [15:0] ref_temp_centikelvin;
  logic [15:0] beta_kelvin;
  logic [15:0] abs_zero_centikelvin;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_full_scale           <= RST_ADC_FULL_SCALE;
      adc_ref_millivolt        <= RST_ADC_REF_MV;
      divider_supply_millivolt <= RST_DIV_SUPPLY_MV;
      divider_ohms             <= RST_DIV_OHMS;
      ntc_nominal_ohms         <= RST_NTC_NOMINAL_OHMS;
      ref_temp_centikelvin     <= RST_REF_TEMP_CK;
      beta_kelvin              <= RST_BETA_K;
      abs_zero_centikelvin     <= RST_ABS_ZERO_CK;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ADC_FULL_SCALE:   adc_full_scale           <= cfg_wdata[15:0];
        REG_ADC_REF_MV:       adc_ref_millivolt        <= cfg_wdata[15:0];
        REG_DIV_SUPPLY_MV:    divider_supply_millivolt <= cfg_wdata[15:0];
        REG_DIV_OHMS:         divider_ohms             <= cfg_wdata;
        REG_NTC_NOMINAL_OHMS: ntc_nominal_ohms         <= cfg_wdata;
        REG_REF_TEMP_CK:      ref_temp_centikelvin     <= cfg_wdata[15:0];
        REG_BETA_K:           beta_kelvin              <= cfg_wdata[15:0];
        REG_ABS_ZERO_CK:      abs_zero_centikelvin     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = result.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en[NS-1:0] & {vld[NS-2:0], sample.valid}) | (~en[NS-1:0] & vld);
    end
  end

  assign sample.ready = en[0];

  // Stage 1: converter voltage numerator and full-scale product
  logic [15:0] smp16;
  logic [31:0] p1_vnum;
  logic [31:0] p1_vfull;

  assign smp16 = 16'(sample.adc_sample[ADC_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_vnum  <= {16'd0, smp16} * {16'd0, adc_ref_millivolt};
      p1_vfull <= {16'd0, divider_supply_millivolt} * {16'd0, adc_full_scale};
    end
  end

  // Stage 2: resistance numerator and denominator, early exceptions
  logic [55:0] p2_num;
  logic [31:0] p2_den;
  tag_t        p2_tag;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2_num <= 56'(p1_vnum) * 56'(divider_ohms);
      p2_den <= p1_vfull - p1_vnum;
      if (p1_vnum == 32'd0 || divider_ohms == 24'd0) begin
        p2_tag <= '{special: 1'b1, code: ST_ZERO};
      end else if (p1_vnum >= p1_vfull) begin
        p2_tag <= '{special: 1'b1, code: ST_SUPPLY};
      end else if (ntc_nominal_ohms == 24'd0) begin
        p2_tag <= '{special: 1'b1, code: ST_SAT};
      end else begin
        p2_tag <= '{special: 1'b0, code: ST_OK};
      end
    end
  end

  // Stage 3: coarse leading-one search of the three log2 operands
  norm_t p3_cn, p3_cd, p3_cr;
  tag_t  p3_tag;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p3_cn  <= norm_coarse(64'(p2_num));
      p3_cd  <= norm_coarse(64'(p2_den));
      p3_cr  <= norm_coarse(64'(ntc_nominal_ohms));
      p3_tag <= p2_tag;
    end
  end

  // Stage 4: fine leading-one and fraction
  fine_t p4_fn, p4_fd, p4_fr;
  tag_t  p4_tag;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p4_fn  <= norm_fine(p3_cn);
      p4_fd  <= norm_fine(p3_cd);
      p4_fr  <= norm_fine(p3_cr);
      p4_tag <= p3_tag;
    end
  end

  // Stage 5: log table reads
  tab_rd_t p5_tn, p5_td, p5_tr;
  tag_t    p5_tag;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p5_tn  <= tab_lookup(p4_fn);
      p5_td  <= tab_lookup(p4_fd);
      p5_tr  <= tab_lookup(p4_fr);
      p5_tag <= p4_tag;
    end
  end

  // Stage 6: interpolate each log2
  logic [30:0] p6_ln, p6_ld, p6_lr;
  tag_t        p6_tag;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p6_ln  <= tab_interp(p5_tn);
      p6_ld  <= tab_interp(p5_td);
      p6_lr  <= tab_interp(p5_tr);
      p6_tag <= p5_tag;
    end
  end

  // Stage 7: log2(R/R0) as sign and magnitude
  logic signed [31:0] l2;
  logic [30:0]        p7_mag;
  logic               p7_neg;
  tag_t               p7_tag;

  assign l2 = $signed({1'b0, p6_ln}) - $signed({1'b0, p6_ld}) - $signed({1'b0, p6_lr});

  always_ff @(posedge clk) begin
    if (en[6]) begin
      p7_neg <= l2[31];
      p7_mag <= l2[31] ? 31'(-l2) : l2[30:0];
      p7_tag <= p6_tag;
    end
  end

  // Stage 8: scale by ln(2), round half away from zero to Q20
  logic [60:0] ln_prod;
  logic [26:0] p8_lmag;
  logic        p8_neg;
  tag_t        p8_tag;

  assign ln_prod = 61'(p7_mag) * 61'(LN2_Q30) + (61'd1 << 33);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      p8_lmag <= ln_prod[60:34];
      p8_neg  <= p7_neg;
      p8_tag  <= p7_tag;
    end
  end

  // Stage 9: L*T0 and T0*B
  logic [42:0] p9_p;
  logic [31:0] p9_tb;
  logic        p9_neg;
  tag_t        p9_tag;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      p9_p   <= 43'(p8_lmag) * 43'(ref_temp_centikelvin);
      p9_tb  <= {16'd0, ref_temp_centikelvin} * {16'd0, beta_kelvin};
      p9_neg <= p8_neg;
      p9_tag <= p8_tag;
    end
  end

  // Stage 10: Beta denominator and scaled numerator
  logic [44:0]        base;
  logic signed [44:0] p10_d;
  logic [58:0]        p10_nn;
  tag_t               p10_tag;

  assign base = (45'(beta_kelvin) * 45'd100) << 20;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      p10_d   <= p9_neg ? $signed(base - 45'(p9_p)) : $signed(base + 45'(p9_p));
      p10_nn  <= (59'(p9_tb) * 59'd100) << 20;
      p10_tag <= p9_tag;
    end
  end

  // Stage 11: rounded dividend, range check, divider entry
  div_t              dv [0:DQ];
  logic              dpos;
  logic [DIV_DW-1:0] dd;
  logic [DIV_RW-1:0] np;

  assign dpos = !p10_d[44] && (p10_d != 45'sd0);
  assign dd   = p10_d[DIV_DW-1:0];
  assign np   = DIV_RW'(p10_nn) + DIV_RW'(dd >> 1);

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      dv[0].tag  <= p10_tag;
      dv[0].dneg <= !dpos;
      dv[0].ovf  <= np >= (DIV_RW'(dd) << DQ);
      dv[0].r    <= np;
      dv[0].d    <= dd;
      dv[0].q    <= '0;
    end
  end

  // Restoring divider: one quotient bit per stage, MSB first
  for (genvar j = 1; j <= DQ; j++) begin : g_div
    localparam int K = DQ - j;
    logic [DIV_RW-1:0] ds;
    div_t              dv_next;

    assign ds = DIV_RW'(dv[j-1].d) << K;

    // Subtract the shifted divisor where it fits and set the quotient bit
    always_comb begin
      dv_next = dv[j-1];
      if (dv[j-1].r >= ds) begin
        dv_next.r    = dv[j-1].r - ds;
        dv_next.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV0 + j]) begin
        dv[j] <= dv_next;
      end
    end
  end

  // Output stage: subtract the Celsius offset, saturate, pick status
  logic signed [18:0] diff19;
  logic signed [18:0] zk19;
  logic signed [15:0] fin_temp;
  status_t            fin_status;
  logic signed [15:0] out_temp;
  status_t            out_status;

  always_comb begin
    diff19 = $signed({2'b00, dv[DQ].q}) - $signed({3'b000, abs_zero_centikelvin});
    zk19 = -$signed({3'b000, abs_zero_centikelvin});
    if (dv[DQ].tag.special) begin
      fin_temp   = sat16(zk19);
      fin_status = dv[DQ].tag.code;
    end else if (dv[DQ].dneg || dv[DQ].ovf) begin
      fin_temp   = TEMP_MAX;
      fin_status = ST_SAT;
    end else begin
      fin_temp   = sat16(diff19);
      fin_status = (diff19 > 19'sd32767 || diff19 < -19'sd32768) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_temp   <= fin_temp;
      out_status <= fin_status;
    end
  end

  assign result.valid              = vld[NS-1];
  assign result.temp_centi_celsius = out_temp;
  assign result.status             = out_status;

endmodule

// File: design/ntc_chk.sv
// Port-level checker for the NTC thermistor temperature block, bound to the top.
// Depends on ntc_pkg and ntc_thermistor_beta_temperature_defines.svh.
`include "ntc_thermistor_beta_temperature_defines.svh"

module ntc_chk
  import ntc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic signed [15:0] temp,
  input logic [1:0]         status
);

  // Hold a stalled result
  `NTC_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(temp) && $stable(status), "result changed while stalled")

  // Zero resistance and supply overrange report absolute zero, never above 0 C
  `NTC_ASSERT_SAME(a_cold_fault, valid && (status == ST_ZERO || status == ST_SUPPLY), temp <= 16'sd0, "fault result above zero")

  // Drop all results on reset
  `NTC_ASSERT_SAME(a_reset_empty, $past(rst), !valid, "result valid right after reset")

endmodule

bind ntc_thermistor_beta_temperature ntc_chk u_ntc_chk (
  .clk    (clk),
  .rst    (rst),
  .valid  (result.valid),
  .ready  (result.ready),
  .temp   (result.temp_centi_celsius),
  .status (result.status)
);
